// ===== design/asr_pkg.sv =====
// Shared types and codes for the allocation size registry.
package asr_pkg;

   localparam int FIELD_W = 48;

   localparam logic [1:0] KIND_REGISTER   = 2'd0;
   localparam logic [1:0] KIND_UNREGISTER = 2'd1;
   localparam logic [1:0] KIND_LOOKUP     = 2'd2;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NULL      = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [FIELD_W-1:0] address;
      logic [FIELD_W-1:0] alloc_size;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [FIELD_W-1:0] found_size;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_READ_LAST,
      ST_MOVE
   } state_type;

   typedef struct packed {
      logic       load_req;
      logic       scan_start;
      logic       scan_run;
      logic       read_last;
      logic       write_append;
      logic       write_move;
      logic       latch_pos;
      logic       respond;
      status_type rsp_status;
      logic       rsp_found;
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       key_zero;
      logic       size_zero;
      logic       full;
      logic       empty;
      logic       hit;
      logic       scan_last;
   } dp_status_type;

endpackage

// ===== design/asr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module asr_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/asr_datapath.sv =====
// Datapath of the allocation size registry: request, count, scan and record table.
module asr_datapath #(
   parameter int ENTRIES   = 256,
   parameter int ADDR_BITS = 48
) (
   input  logic                   clock,
   input  logic                   reset,
   input  asr_pkg::req_type       req_data,
   input  asr_pkg::cmd_type       cmd,
   output asr_pkg::dp_status_type sts,
   output logic                   rsp_strobe,
   output asr_pkg::rsp_type       rsp_data
);

   localparam int FW     = asr_pkg::FIELD_W;
   localparam int KEY_W  = (ADDR_BITS < FW) ? ADDR_BITS : FW;
   localparam int WORD_W = KEY_W + FW;
   localparam int IDX_W  = $clog2(ENTRIES);
   localparam int CNT_W  = $clog2(ENTRIES + 1);

   logic [1:0]       kind_ff;
   logic [KEY_W-1:0] key_ff;
   logic [FW-1:0]    size_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] issue_ff, issue_in;
   logic             rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   asr_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic             issue_go;
   logic [CNT_W-1:0] last_cnt;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic [IDX_W-1:0] rd_addr;
   logic [WORD_W-1:0] rd_data;

   asr_ram #(
      .WIDTH(WORD_W),
      .DEPTH(ENTRIES)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign last_cnt = count_ff - CNT_W'(1);
   assign issue_go = cmd.scan_run && (issue_ff < count_ff);
   assign rd_addr  = cmd.read_last ? last_cnt[IDX_W-1:0] : issue_ff[IDX_W-1:0];
   assign wr_en    = cmd.write_append | cmd.write_move;
   assign wr_addr  = cmd.write_append ? count_ff[IDX_W-1:0] : pos_ff;
   assign wr_data  = cmd.write_append ? {key_ff, size_ff} : rd_data;

   always_comb begin
      issue_in      = cmd.scan_start ? '0 : (issue_go ? issue_ff + CNT_W'(1) : issue_ff);
      rd_valid_in   = issue_go;
      cmp_idx_in    = issue_go ? issue_ff[IDX_W-1:0] : cmp_idx_ff;
      pos_in        = cmd.latch_pos ? cmp_idx_ff : pos_ff;
      count_in      = count_ff;
      if (cmd.write_append) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.write_move) begin
         count_in = last_cnt;
      end
      rsp_strobe_in          = cmd.respond;
      rsp_data_in.status     = cmd.rsp_status;
      rsp_data_in.found_size = cmd.rsp_found ? rd_data[FW-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rd_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rd_valid_ff   <= rd_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         kind_ff <= req_data.kind;
         key_ff  <= req_data.address[KEY_W-1:0];
         size_ff <= req_data.alloc_size;
      end
      issue_ff    <= issue_in;
      cmp_idx_ff  <= cmp_idx_in;
      pos_ff      <= pos_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      sts.kind      = kind_ff;
      sts.key_zero  = (key_ff == '0);
      sts.size_zero = (size_ff == '0);
      sts.full      = (count_ff == CNT_W'(ENTRIES));
      sts.empty     = (count_ff == '0);
      sts.hit       = rd_valid_ff && (rd_data[WORD_W-1:FW] == key_ff);
      sts.scan_last = rd_valid_ff && (CNT_W'(cmp_idx_ff) == last_cnt);
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

// ===== design/asr_ctrl.sv =====
// Controller state machine of the allocation size registry.
module asr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  asr_pkg::dp_status_type sts,
   output asr_pkg::cmd_type       cmd
);

   asr_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= asr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.rsp_status = asr_pkg::STATUS_NULL;
      cmd.scan_run   = (state_ff == asr_pkg::ST_SCAN);
      case (state_ff)
         asr_pkg::ST_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               state_in     = asr_pkg::ST_DECODE;
            end
         end
         asr_pkg::ST_DECODE: begin
            state_in = asr_pkg::ST_IDLE;
            if (sts.kind == asr_pkg::KIND_REGISTER) begin
               cmd.respond = 1'b1;
               if (sts.key_zero || sts.size_zero) begin
                  cmd.rsp_status = asr_pkg::STATUS_NULL;
               end else if (sts.full) begin
                  cmd.rsp_status = asr_pkg::STATUS_FULL;
               end else begin
                  cmd.write_append = 1'b1;
                  cmd.rsp_status   = asr_pkg::STATUS_OK;
               end
            end else if (sts.kind == asr_pkg::KIND_UNREGISTER ||
                         sts.kind == asr_pkg::KIND_LOOKUP) begin
               if (sts.key_zero) begin
                  cmd.respond    = 1'b1;
                  cmd.rsp_status = asr_pkg::STATUS_NULL;
               end else if (sts.empty) begin
                  cmd.respond    = 1'b1;
                  cmd.rsp_status = asr_pkg::STATUS_NOT_FOUND;
               end else begin
                  cmd.scan_start = 1'b1;
                  state_in       = asr_pkg::ST_SCAN;
               end
            end else begin
               cmd.respond    = 1'b1;
               cmd.rsp_status = asr_pkg::STATUS_NULL;
            end
         end
         asr_pkg::ST_SCAN: begin
            if (sts.hit) begin
               if (sts.kind == asr_pkg::KIND_LOOKUP) begin
                  cmd.respond    = 1'b1;
                  cmd.rsp_found  = 1'b1;
                  cmd.rsp_status = asr_pkg::STATUS_OK;
                  state_in       = asr_pkg::ST_IDLE;
               end else begin
                  cmd.latch_pos = 1'b1;
                  state_in      = asr_pkg::ST_READ_LAST;
               end
            end else if (sts.scan_last) begin
               cmd.respond    = 1'b1;
               cmd.rsp_status = asr_pkg::STATUS_NOT_FOUND;
               state_in       = asr_pkg::ST_IDLE;
            end
         end
         asr_pkg::ST_READ_LAST: begin
            cmd.read_last = 1'b1;
            state_in      = asr_pkg::ST_MOVE;
         end
         asr_pkg::ST_MOVE: begin
            cmd.write_move = 1'b1;
            cmd.respond    = 1'b1;
            cmd.rsp_status = asr_pkg::STATUS_OK;
            state_in       = asr_pkg::ST_IDLE;
         end
         default: begin
            state_in = asr_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != asr_pkg::ST_IDLE);

endmodule

// ===== design/allocation_size_registry_core.sv =====
// Allocation size registry: unordered table of (address, size) records.
// Usage:
//   Drive req_data and raise start; the transaction is taken at a clock edge
//   where start is high and busy is low. busy stays high until the result is
//   issued. Each transaction yields one result on rsp_data, valid for exactly
//   one cycle while rsp_strobe is high; the receiver cannot stall it.
// Kinds: register appends a record, unregister finds the first record with the
//   address and moves the last record into its slot, lookup returns its size.
// Steps: register, rejected and empty-table requests respond from decode;
//   lookup and unregister scan from the first record, and an unregister hit
//   then reads the last record and moves it into the slot of the hit.
//   One transaction is handled at a time; the next start is taken in the
//   cycle the result is shown. The scan reads one record per cycle through
//   the single read port of the record memory.
// Reset clears the record count and the controller; the memory is not cleared,
//   since only records below the count are ever read.
module allocation_size_registry_core #(
   parameter int ENTRIES   = 256,
   parameter int ADDR_BITS = 48
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  asr_pkg::req_type req_data,
   output logic             rsp_strobe,
   output asr_pkg::rsp_type rsp_data
);

   asr_pkg::cmd_type       cmd;
   asr_pkg::dp_status_type sts;

   asr_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy (busy),
      .sts  (sts),
      .cmd  (cmd)
   );

   asr_datapath #(
      .ENTRIES  (ENTRIES),
      .ADDR_BITS(ADDR_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the allocation size registry core.
`timescale 1ns / 1ps

module tb_top;

   localparam int ENTRIES   = 256;
   localparam int ADDR_BITS = 48;
   localparam int POOL_SIZE = 48;
   localparam int FIELD_W   = asr_pkg::FIELD_W;
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam logic [FIELD_W-1:0] FIELD_MAX = '1;
   localparam logic [FIELD_W-1:0] FIELD_ZERO = '0;

   class registry_tracker;
      logic [FIELD_W-1:0] rec_address [ENTRIES];
      logic [FIELD_W-1:0] rec_length [ENTRIES];
      int rec_count;
      asr_pkg::rsp_type expected_rsp [$];
      int failures;

      function int find_first(logic [FIELD_W-1:0] key);
         for (int i = 0; i < rec_count; i++)
            if (rec_address[i] == key) return i;
         return -1;
      endfunction

      function void note_request(asr_pkg::req_type r);
         asr_pkg::rsp_type e;
         int pos;
         e.status = asr_pkg::STATUS_NULL;
         e.found_size = '0;
         case (r.kind)
            asr_pkg::KIND_REGISTER: begin
               if (r.address == '0 || r.alloc_size == '0) begin
                  e.status = asr_pkg::STATUS_NULL;
               end else if (rec_count >= ENTRIES) begin
                  e.status = asr_pkg::STATUS_FULL;
               end else begin
                  rec_address[rec_count] = r.address;
                  rec_length[rec_count] = r.alloc_size;
                  rec_count++;
                  e.status = asr_pkg::STATUS_OK;
               end
            end
            asr_pkg::KIND_UNREGISTER, asr_pkg::KIND_LOOKUP: begin
               if (r.address != '0) begin
                  pos = find_first(r.address);
                  if (pos < 0) begin
                     e.status = asr_pkg::STATUS_NOT_FOUND;
                  end else begin
                     e.status = asr_pkg::STATUS_OK;
                     if (r.kind == asr_pkg::KIND_LOOKUP) begin
                        e.found_size = rec_length[pos];
                     end else begin
                        rec_count--;
                        rec_address[pos] = rec_address[rec_count];
                        rec_length[pos] = rec_length[rec_count];
                     end
                  end
               end
            end
            default: ;
         endcase
         expected_rsp.push_back(e);
      endfunction

      function void check_response(asr_pkg::rsp_type got);
         asr_pkg::rsp_type e;
         if (expected_rsp.size() == 0) begin
            $error("response with no transaction waiting: status %0d found_size %0h",
                   got.status, got.found_size);
            failures++;
            return;
         end
         e = expected_rsp.pop_front();
         if (got.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, got.status);
            failures++;
         end
         if (got.found_size !== e.found_size) begin
            $error("found_size: expected %0h, got %0h", e.found_size, got.found_size);
            failures++;
         end
      endfunction
   endclass

   logic             clock;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   asr_pkg::req_type req_data = '0;
   logic             rsp_strobe;
   asr_pkg::rsp_type rsp_data;

   registry_tracker tracker = new;
   logic [FIELD_W-1:0] addr_pool [POOL_SIZE];
   bit idle_on = 1'b1;

   allocation_size_registry_core #(
      .ENTRIES   (ENTRIES),
      .ADDR_BITS (ADDR_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #18_000_000;
      $display("allocation_size_registry_core verification failed");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) tracker.check_response(rsp_data);
         if (start && !busy) tracker.note_request(req_data);
      end
   end

   function automatic logic [FIELD_W-1:0] rand_field();
      logic [63:0] v;
      v = {$urandom(), $urandom()};
      return v[FIELD_W-1:0];
   endfunction

   function automatic asr_pkg::req_type random_request(int reg_pct, int unreg_pct);
      asr_pkg::req_type r;
      int pick;
      pick = $urandom_range(99);
      if (pick < reg_pct) r.kind = asr_pkg::KIND_REGISTER;
      else if (pick < reg_pct + unreg_pct) r.kind = asr_pkg::KIND_UNREGISTER;
      else if (pick < 97) r.kind = asr_pkg::KIND_LOOKUP;
      else r.kind = KIND_UNUSED;
      pick = $urandom_range(99);
      if (pick < 4) r.address = '0;
      else if (pick < 12) r.address = rand_field();
      else r.address = addr_pool[$urandom_range(POOL_SIZE - 1)];
      pick = $urandom_range(99);
      if (pick < 3) r.alloc_size = '0;
      else if (pick < 8) r.alloc_size = FIELD_MAX;
      else if (pick < 20) r.alloc_size = FIELD_W'($urandom_range(1, 255));
      else r.alloc_size = rand_field();
      return r;
   endfunction

   task automatic issue(asr_pkg::req_type r);
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      if (idle_on && $urandom_range(99) < 22) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic drain_pending();
      start <= 1'b0;
      do @(posedge clock); while (tracker.expected_rsp.size() != 0);
   endtask

   task automatic run_phase(int items, int reg_pct, int unreg_pct);
      repeat (items) issue(random_request(reg_pct, unreg_pct));
   endtask

   initial begin
      addr_pool[0] = FIELD_MAX;
      addr_pool[1] = FIELD_W'(1);
      addr_pool[2] = 48'hAAAA_AAAA_AAAA;
      addr_pool[3] = 48'h5555_5555_5555;
      for (int i = 4; i < POOL_SIZE; i++) begin
         addr_pool[i] = (i < 10) ? FIELD_W'(i) : rand_field();
         if (addr_pool[i] == '0) addr_pool[i] = FIELD_W'(i);
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      issue(asr_pkg::req_type'{asr_pkg::KIND_LOOKUP, 48'h1234, FIELD_ZERO});
      issue(asr_pkg::req_type'{asr_pkg::KIND_UNREGISTER, 48'h1234, FIELD_ZERO});
      issue(asr_pkg::req_type'{asr_pkg::KIND_REGISTER, FIELD_ZERO, 48'h5});
      issue(asr_pkg::req_type'{asr_pkg::KIND_REGISTER, 48'h5, FIELD_ZERO});
      issue(asr_pkg::req_type'{asr_pkg::KIND_REGISTER, FIELD_MAX, FIELD_MAX});
      issue(asr_pkg::req_type'{asr_pkg::KIND_REGISTER, 48'h1, 48'h1});
      issue(asr_pkg::req_type'{asr_pkg::KIND_REGISTER, FIELD_MAX, 48'h7});
      issue(asr_pkg::req_type'{asr_pkg::KIND_REGISTER, 48'hAAAA_AAAA_AAAA,
                               48'h5555_5555_5555});
      issue(asr_pkg::req_type'{asr_pkg::KIND_REGISTER, 48'h5555_5555_5555,
                               48'hAAAA_AAAA_AAAA});
      issue(asr_pkg::req_type'{asr_pkg::KIND_LOOKUP, FIELD_MAX, FIELD_MAX});
      issue(asr_pkg::req_type'{asr_pkg::KIND_LOOKUP, 48'h5555_5555_5555, FIELD_ZERO});
      issue(asr_pkg::req_type'{asr_pkg::KIND_LOOKUP, FIELD_ZERO, FIELD_ZERO});
      issue(asr_pkg::req_type'{asr_pkg::KIND_UNREGISTER, FIELD_ZERO, FIELD_MAX});
      issue(asr_pkg::req_type'{KIND_UNUSED, 48'hAAAA_AAAA_AAAA, FIELD_MAX});
      issue(asr_pkg::req_type'{KIND_UNUSED, FIELD_MAX, FIELD_ZERO});
      issue(asr_pkg::req_type'{asr_pkg::KIND_UNREGISTER, FIELD_MAX, FIELD_ZERO});
      issue(asr_pkg::req_type'{asr_pkg::KIND_LOOKUP, FIELD_MAX, FIELD_ZERO});
      issue(asr_pkg::req_type'{asr_pkg::KIND_UNREGISTER, 48'h1, FIELD_ZERO});
      issue(asr_pkg::req_type'{asr_pkg::KIND_LOOKUP, 48'h1, FIELD_ZERO});
      issue(asr_pkg::req_type'{asr_pkg::KIND_UNREGISTER, 48'h5555_5555_5555,
                               FIELD_ZERO});
      issue(asr_pkg::req_type'{asr_pkg::KIND_LOOKUP, 48'hAAAA_AAAA_AAAA, FIELD_ZERO});
      issue(asr_pkg::req_type'{asr_pkg::KIND_UNREGISTER, 48'h9876_5432_10FE,
                               FIELD_ZERO});

      run_phase(200, 35, 25);
      // fill past capacity, then hold until the table is settled
      run_phase(340, 88, 3);
      drain_pending();
      run_phase(260, 5, 80);
      idle_on = 1'b0;
      run_phase(120, 40, 30);
      idle_on = 1'b1;
      run_phase(110, 40, 30);

      drain_pending();
      repeat (20) @(posedge clock);
      if (tracker.failures == 0 && tracker.expected_rsp.size() == 0)
         $display("allocation_size_registry_core verification clean");
      else
         $display("allocation_size_registry_core verification failed");
      $finish;
   end

endmodule
